// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; each macro takes a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tlbs_pkg.sv =====
// Package of the table search block: sizes, command codes and item types.
// Depends on nothing; used by every module of the block.
package tlbs_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned PosW         = 5;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LINEAR = 2'd2,
    CMD_BINARY = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [ValueW-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            table_full_error;
  } res_item_t;

endpackage

// ===== hdl/tlbs_mem.sv =====
// Entry store of the table: one write port and one read port, read data registered.
// Depends on tlbs_pkg for the value width.
module tlbs_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [IdxW-1:0]                    waddr_i,
  input  logic signed [tlbs_pkg::ValueW-1:0] wdata_i,
  input  logic [IdxW-1:0]                    raddr_i,
  output logic signed [tlbs_pkg::ValueW-1:0] rdata_o
);
  import tlbs_pkg::*;

  logic signed [ValueW-1:0] mem_q [DEPTH];
  logic signed [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tlbs_ctrl.sv =====
// Command sequencer of the table search block with its single key comparator.
// Depends on tlbs_pkg; drives the read and write ports of tlbs_mem.
module tlbs_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IdxW  = 4,
  parameter int unsigned CntW  = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  tlbs_pkg::cmd_item_t                cmd_i,
  output logic                               done_o,
  output tlbs_pkg::res_item_t                res_o,
  output logic                               we_o,
  output logic [IdxW-1:0]                    waddr_o,
  output logic [IdxW-1:0]                    raddr_o,
  input  logic signed [tlbs_pkg::ValueW-1:0] rdata_i
);
  import tlbs_pkg::*;

  localparam int unsigned BW = CntW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CMP  = 2'b10
  } state_e;

  state_e                   state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [IdxW-1:0]          addr_q, addr_d;
  logic signed [BW-1:0]     low_q, low_d, high_q, high_d;
  logic signed [ValueW-1:0] key_q, key_d;
  logic                     bin_q, bin_d;
  logic                     done_q, done_d;
  res_item_t                res_q, res_d;

  logic                     full;
  logic                     key_eq, key_gt;
  logic [IdxW:0]            addr_inc;
  logic signed [BW-1:0]     addr_s, high0, nlow, nhigh;
  logic signed [BW:0]       mid_sum0, mid_sum;

  assign full = (cnt_q == CntW'(DEPTH));

  // The shared comparator: every probe of either search goes through it.
  assign key_eq = (key_q == rdata_i);
  assign key_gt = (key_q > rdata_i);

  assign addr_inc = {1'b0, addr_q} + 1'b1;
  assign addr_s   = signed'(BW'(addr_q));
  assign high0    = signed'(BW'(cnt_q)) - signed'(BW'(1));
  assign mid_sum0 = (BW + 1)'(high0);
  assign nlow     = key_gt ? addr_s + signed'(BW'(1)) : low_q;
  assign nhigh    = key_gt ? high_q : addr_s - signed'(BW'(1));
  assign mid_sum  = (BW + 1)'(nlow) + (BW + 1)'(nhigh);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    low_d   = low_q;
    high_d  = high_q;
    key_d   = key_q;
    bin_d   = bin_q;
    done_d  = 1'b0;
    res_d   = '0;
    we_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.command)
            CMD_CLEAR: begin
              cnt_d  = '0;
              done_d = 1'b1;
            end
            CMD_APPEND: begin
              done_d = 1'b1;
              if (full) begin
                res_d.table_full_error = 1'b1;
              end else begin
                we_o  = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_LINEAR: begin
              key_d = cmd_i.value;
              bin_d = 1'b0;
              if (cnt_q == '0) begin
                done_d = 1'b1;
              end else begin
                addr_d  = '0;
                state_d = ST_CMP;
              end
            end
            CMD_BINARY: begin
              key_d  = cmd_i.value;
              bin_d  = 1'b1;
              low_d  = '0;
              high_d = high0;
              if (cnt_q == '0) begin
                done_d = 1'b1;
              end else begin
                addr_d  = mid_sum0[IdxW:1];
                state_d = ST_CMP;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_CMP: begin
        if (key_eq) begin
          done_d         = 1'b1;
          res_d.found    = 1'b1;
          res_d.position = PosW'(addr_inc);
          state_d        = ST_IDLE;
        end else if (!bin_q) begin
          if (CntW'(addr_inc) == cnt_q) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            addr_d = IdxW'(addr_inc);
          end
        end else begin
          low_d  = nlow;
          high_d = nhigh;
          // Bounds crossed: the probe path ends without a match.
          if (nlow > nhigh) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            addr_d = mid_sum[IdxW:1];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    low_q  <= low_d;
    high_q <= high_d;
    key_q  <= key_d;
    bin_q  <= bin_d;
    res_q  <= res_d;
  end

  // The read address is the next probe, so its entry arrives with the probe state.
  assign raddr_o = addr_d;
  assign waddr_o = cnt_q[IdxW-1:0];
  assign busy    = (state_q != ST_IDLE);
  assign done_o  = done_q;
  assign res_o   = res_q;

endmodule

// ===== hdl/table_linear_binary_search.sv =====
// Top level of the table search block: sequencer and entry store.
// Depends on tlbs_pkg, tlbs_ctrl and tlbs_mem.
//
//   channel   ports                 handshake
//   command   cmd_i                 taken when start is high and busy is low
//   result    res_o                 shown for one cycle while done_o is high
//
// Clear and append show their result in the cycle after the item is taken,
// and busy stays low, so the next item may follow at once.
// A search of a non-empty table keeps busy high while it probes one entry at a time:
// up to the entry count for a linear search, up to floor(log2(count))+1 for a
// binary search, set by the one read port of the store and the one key comparator.
// Reset empties the table at once; entries need no clearing.
// The receiver cannot stall: a result is gone after its strobe cycle.
module table_linear_binary_search #(
  parameter int unsigned DEPTH = tlbs_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tlbs_pkg::cmd_item_t cmd_i,
  output logic                done_o,
  output tlbs_pkg::res_item_t res_o
);
  import tlbs_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                     we;
  logic [IdxW-1:0]          waddr, raddr;
  logic signed [ValueW-1:0] rdata;

  tlbs_ctrl #(
    .DEPTH (DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .we_o    (we),
    .waddr_o (waddr),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  tlbs_mem #(
    .DEPTH (DEPTH),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== hdl/tlbs_checker.sv =====
// Port-level checks of the table search block, bound to its top level.
// Depends on tlbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlbs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input tlbs_pkg::cmd_item_t cmd_i,
  input logic                done_o,
  input tlbs_pkg::res_item_t res_o
);
  import tlbs_pkg::*;

  logic take;
  assign take = start && !busy;

  `ASSERT_SAME(a_flags_excl, clk_i, rst_ni, done_o, !(res_o.found && res_o.table_full_error), "found and full error together")
  `ASSERT_SAME(a_miss_no_pos, clk_i, rst_ni, done_o && !res_o.found, res_o.position == '0, "position set without a match")
  `ASSERT_NEXT(a_quick_cmds, clk_i, rst_ni, take && (cmd_i.command == CMD_CLEAR || cmd_i.command == CMD_APPEND), done_o && !busy, "clear or append result late")
  `ASSERT_NEXT(a_search_acts, clk_i, rst_ni, take && (cmd_i.command == CMD_LINEAR || cmd_i.command == CMD_BINARY), busy || done_o, "search item dropped")
  `ASSERT_SAME(a_end_result, clk_i, rst_ni, $fell(busy), done_o, "search ended without a result")

endmodule

bind table_linear_binary_search tlbs_checker u_tlbs_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the table search block: directed and random command streams,
// checked field by field against an in-bench model of the table.
// Depends on tlbs_pkg and table_linear_binary_search.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlbs_pkg::*;

  localparam int unsigned TableDepth  = DefaultDepth;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TailCycles  = 2 * TableDepth + 4;

  typedef struct {
    cmd_item_t item;
    bit        wait_for_empty;
  } queued_cmd_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  cmd_item_t cmd_i  = '0;
  logic      busy;
  logic      done_o;
  res_item_t res_o;

  table_linear_binary_search #(
    .DEPTH(TableDepth)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of the stored values and the fill level.
  logic signed [ValueW-1:0] model_entries [TableDepth];
  int unsigned              model_count = 0;

  queued_cmd_t cmd_backlog_q [$];
  res_item_t   expected_res_q [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned cmd_taken [4]  = '{0, 0, 0, 0};
  int unsigned results_seen   = 0;
  int unsigned hits_seen      = 0;
  int unsigned full_errs_seen = 0;
  int unsigned idle_left      = 0;
  int unsigned no_idle_left   = 0;

  // Applies one command to the model table and returns the result it yields.
  function automatic res_item_t search_table_result(cmd_item_t it);
    res_item_t                r;
    logic signed [ValueW-1:0] key;
    int                       lo;
    int                       hi;
    int                       mid;
    int unsigned              pos;
    key = it.value;
    r   = '0;
    pos = 0;
    case (cmd_e'(it.command))
      CMD_CLEAR: model_count = 0;
      CMD_APPEND: begin
        if (model_count >= TableDepth) begin
          r.table_full_error = 1'b1;
        end else begin
          model_entries[model_count] = key;
          model_count++;
        end
      end
      CMD_LINEAR: begin
        for (int i = 0; i < model_count; i++) begin
          if (pos == 0 && model_entries[i] == key) pos = i + 1;
        end
      end
      default: begin
        // Bisection probe path; on unsorted data it only reports what it meets.
        lo = 0;
        hi = int'(model_count) - 1;
        while (lo <= hi && pos == 0) begin
          mid = (lo + hi) / 2;
          if (key == model_entries[mid]) pos = mid + 1;
          else if (key > model_entries[mid]) lo = mid + 1;
          else hi = mid - 1;
        end
      end
    endcase
    r.found    = (pos != 0);
    r.position = pos[PosW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_cmd(cmd_e c, logic signed [ValueW-1:0] v, bit drain);
    queued_cmd_t q;
    q.item.command    = c;
    q.item.value      = v;
    q.wait_for_empty  = drain;
    cmd_backlog_q.push_back(q);
  endtask

  // Driver: presents items from the backlog, with random idle gaps.
  always @(posedge clk_i) begin
    bit          took;
    bit          drive;
    queued_cmd_t nxt;
    took  = rst_ni && start && !busy;
    drive = start && !took;
    nxt.item = cmd_i;
    if (took) begin
      expected_res_q.push_back(search_table_result(cmd_i));
      cmd_taken[cmd_i.command]++;
      if (no_idle_left > 0) begin
        no_idle_left--;
        idle_left = 0;
      end else if ($urandom_range(0, 49) == 0) begin
        no_idle_left = $urandom_range(30, 80);
        idle_left    = 0;
      end else if ($urandom_range(0, 9) < 6) begin
        idle_left = 0;
      end else if ($urandom_range(0, 9) < 8) begin
        idle_left = $urandom_range(1, 3);
      end else begin
        idle_left = $urandom_range(8, 40);
      end
    end
    if (rst_ni && !drive) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (cmd_backlog_q.size() > 0 &&
                   !(cmd_backlog_q[0].wait_for_empty && expected_res_q.size() > 0)) begin
        nxt   = cmd_backlog_q.pop_front();
        drive = 1'b1;
      end
    end
    start <= drive;
    cmd_i <= nxt.item;
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni && done_o) begin
      if (expected_res_q.size() == 0) begin
        report_mismatch("result with no item outstanding", 1, 0);
      end else begin
        want = expected_res_q.pop_front();
        results_seen++;
        if (res_o.found) hits_seen++;
        if (res_o.table_full_error) full_errs_seen++;
        if (res_o.found !== want.found)
          report_mismatch("found", res_o.found, want.found);
        if (res_o.position !== want.position)
          report_mismatch("position", res_o.position, want.position);
        if (res_o.table_full_error !== want.table_full_error)
          report_mismatch("table_full_error", res_o.table_full_error,
                          want.table_full_error);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("table_linear_binary_search verification failed");
      $finish;
    end
  end

  initial begin
    logic signed [ValueW-1:0] ramp [16];
    logic signed [ValueW-1:0] vals [$];
    logic signed [ValueW-1:0] v;
    int unsigned              n_queued;
    int unsigned              n_append;
    int unsigned              n_search;
    int unsigned              j;
    bit                       narrow;
    bit                       drain;
    bit                       first_seq;

    ramp = '{32'sh80000000, -32'sd1000000, -32'sd5000, -32'sd300, -32'sd17, -32'sd2,
             -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd40, 32'sd777, 32'sd65536,
             32'sd1000000, 32'sh40000000, 32'sh7FFFFFFF};

    // Directed: empty table, fill to the limit, refused append, edge keys, clear.
    queue_cmd(CMD_LINEAR, 32'sd5, 1'b0);
    queue_cmd(CMD_BINARY, 32'sd5, 1'b0);
    for (int i = 0; i < 16; i++) queue_cmd(CMD_APPEND, ramp[i], 1'b0);
    queue_cmd(CMD_APPEND, 32'sd5, 1'b0);
    queue_cmd(CMD_LINEAR, 32'sh7FFFFFFF, 1'b0);
    queue_cmd(CMD_BINARY, 32'sh80000000, 1'b0);
    queue_cmd(CMD_BINARY, 32'sh7FFFFFFF, 1'b0);
    queue_cmd(CMD_BINARY, 32'sd3, 1'b0);
    queue_cmd(CMD_CLEAR, 32'sd0, 1'b0);
    queue_cmd(CMD_LINEAR, 32'sd0, 1'b0);
    n_queued  = cmd_backlog_q.size();
    first_seq = 1'b1;

    // Random: mostly sorted tables with searches, the rest arbitrary commands.
    while (n_queued < 25 + RandomItems) begin
      drain = first_seq || ($urandom_range(0, 7) == 0);
      first_seq = 1'b0;
      narrow = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 7) begin
        n_append = ($urandom_range(0, 9) < 8) ? $urandom_range(1, TableDepth)
                                              : $urandom_range(TableDepth + 1,
                                                               TableDepth + 3);
        vals.delete();
        for (int i = 0; i < n_append && i < TableDepth; i++) begin
          v = narrow ? int'($urandom_range(0, 60)) - 30 : $urandom;
          j = 0;
          while (j < vals.size() && vals[j] <= v) j++;
          vals.insert(j, v);
        end
        queue_cmd(CMD_CLEAR, $urandom, drain);
        foreach (vals[i]) queue_cmd(CMD_APPEND, vals[i], 1'b0);
        for (int i = TableDepth; i < n_append; i++) queue_cmd(CMD_APPEND, $urandom, 1'b0);
        n_search = $urandom_range(2, 10);
        for (int i = 0; i < n_search; i++) begin
          case ($urandom_range(0, 4))
            0, 1, 2: v = vals[$urandom_range(0, vals.size() - 1)];
            3:       v = vals[$urandom_range(0, vals.size() - 1)] + 1;
            default: v = $urandom;
          endcase
          queue_cmd($urandom_range(0, 1) ? CMD_BINARY : CMD_LINEAR, v, 1'b0);
        end
        n_queued += 1 + n_append + n_search;
      end else begin
        n_search = $urandom_range(1, 8);
        for (int i = 0; i < n_search; i++) begin
          v = narrow ? int'($urandom_range(0, 60)) - 30 : $urandom;
          queue_cmd(cmd_e'($urandom_range(0, 3)), v, drain && i == 0);
        end
        n_queued += n_search;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog_q.size() > 0 || start) @(posedge clk_i);
    while (expected_res_q.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d clears, %0d appends, %0d linear and %0d binary searches.",
             cmd_taken[CMD_CLEAR], cmd_taken[CMD_APPEND], cmd_taken[CMD_LINEAR],
             cmd_taken[CMD_BINARY]);
    $display("Checked %0d results: %0d hits, %0d refused appends, %0d mismatches.",
             results_seen, hits_seen, full_errs_seen, mismatch_count);
    if (mismatch_count == 0 && expected_res_q.size() == 0) begin
      $display("table_linear_binary_search verification clean");
    end else begin
      $display("table_linear_binary_search verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tlbs_pkg.sv
hdl/tlbs_mem.sv
hdl/tlbs_ctrl.sv
hdl/table_linear_binary_search.sv
hdl/tlbs_checker.sv
dv/tb.sv
